[hdl/mers_pkg.sv]
// shared types for the end-removal window search block
package mers_pkg;

  // operation codes of the shared add/subtract unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // status of one pass through the shared unit
  typedef struct packed {
    logic borrow;
    logic zero;
  } alu_flags_t;

endpackage

[hdl/mers_if.sv]
// valid/ready channel interfaces for element beats and result beats
interface mers_in_if #(
  parameter int VALUE_W = 16
);
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mers_out_if #(
  parameter int REM_W = 11
);
  logic             valid;
  logic             ready;
  logic             found;
  logic [REM_W-1:0] removals;
  logic             overflow;

  modport source (output valid, output found, output removals, output overflow, input ready);
  modport sink   (input valid, input found, input removals, input overflow, output ready);
endinterface

[hdl/mers_alu.sv]
// shared add/subtract unit with borrow and zero flags
module mers_alu #(
  parameter int W = 32
) (
  input  mers_pkg::alu_op_t    op,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  output logic [W-1:0]         res,
  output mers_pkg::alu_flags_t flags
);

  logic [W:0] full;

  always_comb begin
    case (op)
      mers_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      mers_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default:           full = '0;
    endcase
  end

  assign res          = full[W-1:0];
  // top bit of a subtraction is set when b exceeds a
  assign flags.borrow = full[W];
  assign flags.zero   = (full[W-1:0] == '0);

endmodule

[hdl/mers_store.sv]
// element memory, one write port and one registered read port
module mers_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/min_end_removals_to_target_sum.sv]
// top level: element loader, window search sequencer and register port
//
// usage
//   in_ch carries one element beat per cycle (value, last); the block takes
//   a beat whenever it is loading, one element per cycle, and stores it
//   while adding it to the running total. elements beyond MAX_ELEMENTS are
//   dropped and flag overflow for the data set.
//   the beat marked last closes the data set; in_ch.ready then stays low
//   while the window search runs over the store.
//   out_ch gives one beat per data set: found, removals, overflow.
//   the trivial outcomes (overflow, target zero, target negative) skip the
//   window search, which is paced by the single add/subtract unit and the
//   one read port of the store.
//   the result sits in an output register; a stalled receiver only holds
//   the block once the next data set is complete, loading goes on meanwhile.
//   amount is written over the apb port at byte address 0 while idle; the
//   block itself leaves this to the user, who alone is bound by it.
//   reset clears the sequencer, counts, flags and sets amount to 1; the
//   store is not cleared, only entries of the current set are ever read.
module min_end_removals_to_target_sum #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int ELEMENT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  mers_in_if.sink      in_ch,
  mers_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SUM_W = ELEMENT_BITS + CNT_W;
  localparam int ALU_W = (SUM_W > 32) ? SUM_W : 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_RD_R,
    S_ADD_R,
    S_CMP,
    S_SUB,
    S_LEN,
    S_BEST,
    S_NEXT,
    S_DONE,
    S_EMIT
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r;
  logic [SUM_W-1:0]        total_r;
  logic [SUM_W-1:0]        target_r;
  logic [SUM_W-1:0]        window_r;
  logic [IDX_W-1:0]        left_r;
  logic [IDX_W-1:0]        right_r;
  logic [CNT_W-1:0]        best_r;
  logic [CNT_W-1:0]        len_r;
  logic                    ovf_r;
  logic                    res_found_r;
  logic [CNT_W-1:0]        res_rem_r;
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [CNT_W-1:0]        out_rem_r;
  logic                    out_ovf_r;
  logic [31:0]             amount_r;

  // shared unit hookup
  mers_pkg::alu_op_t       alu_op;
  logic [ALU_W-1:0]        alu_a;
  logic [ALU_W-1:0]        alu_b;
  logic [ALU_W-1:0]        alu_res;
  mers_pkg::alu_flags_t    alu_flags;

  logic [ELEMENT_BITS-1:0] rd_data;
  logic [IDX_W-1:0]        rd_addr;
  logic                    in_fire;
  logic                    has_room;
  logic                    st_we;
  logic [CNT_W-1:0]        right_inc;
  logic                    out_free;
  logic                    cfg_wr;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign has_room  = (count_r < CNT_W'(MAX_ELEMENTS));
  assign st_we     = in_fire && has_room;
  assign right_inc = CNT_W'(right_r) + CNT_W'(1);
  assign out_free  = !out_valid_r || out_ch.ready;

  // the left element is fetched while comparing, the right one otherwise
  assign rd_addr = (state_r == S_CMP) ? left_r : right_r;

  mers_store #(
    .DEPTH  (MAX_ELEMENTS),
    .DATA_W (ELEMENT_BITS),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_ch.value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // operand selection for the one add/subtract unit, per sequencer step
  always_comb begin
    alu_op = mers_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      S_LOAD: begin
        // running total of the data set
        alu_a = ALU_W'(total_r);
        alu_b = ALU_W'(in_ch.value);
      end
      S_CHECK: begin
        // target = total - amount, borrow means no answer
        alu_op = mers_pkg::ALU_SUB;
        alu_a  = ALU_W'(total_r);
        alu_b  = ALU_W'(amount_r);
      end
      S_ADD_R: begin
        // grow the window to the right
        alu_a = ALU_W'(window_r);
        alu_b = ALU_W'(rd_data);
      end
      S_CMP: begin
        // borrow: window too big, zero: exact match
        alu_op = mers_pkg::ALU_SUB;
        alu_a  = ALU_W'(target_r);
        alu_b  = ALU_W'(window_r);
      end
      S_SUB: begin
        // shrink the window from the left
        alu_op = mers_pkg::ALU_SUB;
        alu_a  = ALU_W'(window_r);
        alu_b  = ALU_W'(rd_data);
      end
      S_LEN: begin
        // run length = right + 1 - left
        alu_op = mers_pkg::ALU_SUB;
        alu_a  = ALU_W'(right_inc);
        alu_b  = ALU_W'(left_r);
      end
      S_BEST: begin
        // borrow when the new run is longer
        alu_op = mers_pkg::ALU_SUB;
        alu_a  = ALU_W'(best_r);
        alu_b  = ALU_W'(len_r);
      end
      S_DONE: begin
        // removals = count - longest run
        alu_op = mers_pkg::ALU_SUB;
        alu_a  = ALU_W'(count_r);
        alu_b  = ALU_W'(best_r);
      end
      default: begin
        alu_op = mers_pkg::ALU_ADD;
      end
    endcase
  end

  mers_alu #(
    .W (ALU_W)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // while emitting, the new beat takes over the output register
      if (out_valid_r && out_ch.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (has_room) begin
              count_r <= count_r + CNT_W'(1);
              total_r <= alu_res[SUM_W-1:0];
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_ch.last) begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (ovf_r) begin
            res_found_r <= 1'b0;
            res_rem_r   <= '0;
            state_r     <= S_EMIT;
          end else if (alu_flags.zero) begin
            // target zero: every element goes
            res_found_r <= 1'b1;
            res_rem_r   <= count_r;
            state_r     <= S_EMIT;
          end else if (alu_flags.borrow) begin
            res_found_r <= 1'b0;
            res_rem_r   <= '0;
            state_r     <= S_EMIT;
          end else begin
            target_r <= alu_res[SUM_W-1:0];
            window_r <= '0;
            left_r   <= '0;
            right_r  <= '0;
            best_r   <= '0;
            state_r  <= S_RD_R;
          end
        end
        S_RD_R: begin
          state_r <= S_ADD_R;
        end
        S_ADD_R: begin
          window_r <= alu_res[SUM_W-1:0];
          state_r  <= S_CMP;
        end
        S_CMP: begin
          if (alu_flags.borrow) begin
            // an empty window cannot exceed a positive target
            state_r <= (left_r <= right_r) ? S_SUB : S_NEXT;
          end else if (alu_flags.zero) begin
            state_r <= S_LEN;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_SUB: begin
          window_r <= alu_res[SUM_W-1:0];
          left_r   <= left_r + IDX_W'(1);
          state_r  <= S_CMP;
        end
        S_LEN: begin
          len_r   <= alu_res[CNT_W-1:0];
          state_r <= S_BEST;
        end
        S_BEST: begin
          if (alu_flags.borrow) begin
            best_r <= len_r;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (right_inc == count_r) begin
            state_r <= S_DONE;
          end else begin
            right_r <= right_inc[IDX_W-1:0];
            state_r <= S_RD_R;
          end
        end
        S_DONE: begin
          // any match has length one or more, so a zero best means none
          res_found_r <= (best_r != '0);
          res_rem_r   <= (best_r != '0) ? alu_res[CNT_W-1:0] : '0;
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_rem_r   <= res_rem_r;
            out_ovf_r   <= ovf_r;
            count_r     <= '0;
            total_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // register port, amount only
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? amount_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r <= 32'd1;
    end else if (cfg_wr && (paddr[2] == 1'b0)) begin
      amount_r <= pwdata;
    end
  end

  assign in_ch.ready     = (state_r == S_LOAD);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.removals = out_rem_r;
  assign out_ch.overflow = out_ovf_r;

endmodule

[hdl/mers_chk.sv]
// port-level checks for the end-removal block, bound to the top level
module mers_chk #(
  parameter int REM_W = 11
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             found,
  input logic [REM_W-1:0] removals,
  input logic             overflow
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(removals)
      && $stable(overflow))
    else $error("result beat changed while stalled");

  // no match reports zero removals
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> removals == '0)
    else $error("removals set without a match");

  // an overflowed set never reports a match
  a_ovf_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> !found)
    else $error("match reported on an overflowed set");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

endmodule

bind min_end_removals_to_target_sum mers_chk #(
  .REM_W ($clog2(MAX_ELEMENTS + 1))
) u_mers_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .found     (out_ch.found),
  .removals  (out_ch.removals),
  .overflow  (out_ch.overflow)
);

[tb/tb.sv]
// self-checking testbench for the end-removal window search block
`timescale 1ns / 100ps

module tb;

  localparam int          STORE_DEPTH  = 1024;
  localparam int          VALUE_W      = 16;
  localparam int          REM_W        = 11;
  localparam logic [2:0]  AMOUNT_ADDR  = 3'd0;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          RANDOM_BEATS = 450;
  localparam int          FULL_PHASE   = 6;
  localparam int          SPILL_PHASE  = 13;

  // one result beat as the block reports it
  typedef struct packed {
    logic             found;
    logic [REM_W-1:0] removals;
    logic             overflow;
  } removal_result_t;

  // tracks the data set being loaded, predicts its answer and checks results
  class removal_scoreboard;
    bit [VALUE_W-1:0] elements[STORE_DEPTH];
    int               loaded;
    longint           running_total;
    bit               spilled;
    bit [31:0]        amount;
    removal_result_t  awaited[$];
    int               errors;

    function new();
      amount = 32'd1;
      clear_set();
    endfunction

    function void clear_set();
      loaded        = 0;
      running_total = 0;
      spilled       = 1'b0;
    endfunction

    function void set_amount(bit [31:0] val);
      amount = val;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // longest run of stored elements summing to target, -1 if none
    function int longest_run(longint target);
      longint win_sum;
      int     lo;
      int     best;
      bit     hit;
      win_sum = 0;
      lo      = 0;
      best    = 0;
      hit     = 1'b0;
      for (int r = 0; r < loaded; r++) begin
        win_sum += elements[r];
        while (win_sum > target && lo <= r) begin
          win_sum -= elements[lo];
          lo++;
        end
        if (win_sum == target) begin
          if (!hit || (r - lo + 1) > best) best = r - lo + 1;
          hit = 1'b1;
        end
      end
      return hit ? best : -1;
    endfunction

    function void note_element(bit [VALUE_W-1:0] val, bit is_last);
      removal_result_t res;
      longint          amt;
      int              run_len;
      if (loaded < STORE_DEPTH) begin
        elements[loaded] = val;
        loaded++;
        running_total += val;
      end else begin
        spilled = 1'b1;
      end
      if (!is_last) return;
      amt      = amount;
      res      = '0;
      res.overflow = spilled;
      if (!spilled) begin
        if (running_total == amt) begin
          res.found    = 1'b1;
          res.removals = loaded[REM_W-1:0];
        end else if (running_total > amt) begin
          run_len = longest_run(running_total - amt);
          if (run_len >= 0) begin
            res.found    = 1'b1;
            res.removals = REM_W'(loaded - run_len);
          end
        end
      end
      awaited.push_back(res);
      clear_set();
    endfunction

    function void check_result(removal_result_t got);
      removal_result_t want;
      if (awaited.size() == 0) begin
        note_mismatch($sformatf("unexpected result found=%0b removals=%0d overflow=%0b",
                                got.found, got.removals, got.overflow));
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found)
        note_mismatch($sformatf("found exp %0b got %0b", want.found, got.found));
      if (got.removals !== want.removals)
        note_mismatch($sformatf("removals exp %0d got %0d", want.removals, got.removals));
      if (got.overflow !== want.overflow)
        note_mismatch($sformatf("overflow exp %0b got %0b", want.overflow, got.overflow));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          cycle_count = 0;

  mers_in_if  #(.VALUE_W(VALUE_W)) in_ch ();
  mers_out_if #(.REM_W(REM_W))     out_ch ();

  removal_scoreboard sb = new();

  // elements of the data set about to be sent
  bit [VALUE_W-1:0] set_values[$];

  min_end_removals_to_target_sum #(
    .MAX_ELEMENTS(STORE_DEPTH),
    .ELEMENT_BITS(VALUE_W)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake or a runaway search ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // every accepted element beat goes to the predictor, every result beat to the checker;
  // values are read before this edge's updates land, so ordering within the step is moot
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_ch.valid && in_ch.ready)
      sb.note_element(in_ch.value, in_ch.last);
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready)
      sb.check_result('{found: out_ch.found, removals: out_ch.removals,
                        overflow: out_ch.overflow});
  end

  // result receiver: may drop ready for a random stall before each beat, with spells of no stalling
  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // apb write of amount, then a read back of the same register
  task automatic write_amount(input bit [31:0] val);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AMOUNT_ADDR;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    // straight into the read setup, psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_amount(val);
    if (readback !== val)
      sb.note_mismatch($sformatf("amount read back exp %0h got %0h", val, readback));
  endtask

  // block is idle once every result is in; a few spare cycles before touching amount
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // send set_values as one data set; burst means no gaps between beats
  task automatic send_set(input bit burst);
    int gap;
    for (int i = 0; i < set_values.size(); i++) begin
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.value <= set_values[i];
      in_ch.last  <= (i == set_values.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
    in_ch.last  <= 1'b0;
    @(posedge clk);
  endtask

  // fill set_values with len elements drawn by style
  task automatic build_set(input int len, input int style);
    set_values.delete();
    for (int i = 0; i < len; i++) begin
      case (style)
        0, 1, 2, 3, 4, 5: set_values.push_back(VALUE_W'($urandom_range(1, 8)));
        6, 7:             set_values.push_back(VALUE_W'($urandom_range(1, 65535)));
        // zero elements sit outside the stated range but the block takes them
        8:                set_values.push_back(VALUE_W'($urandom_range(0, 3)));
        default:          set_values.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'd1);
      endcase
    end
  endtask

  // amount that some prefix plus some suffix of set_values adds up to, one if that sum is zero
  function automatic bit [31:0] reachable_amount();
    int     head;
    int     tail;
    longint sum;
    head = $urandom_range(0, set_values.size());
    tail = $urandom_range(0, set_values.size() - head);
    sum  = 0;
    for (int i = 0; i < head; i++) sum += set_values[i];
    for (int i = 0; i < tail; i++) sum += set_values[set_values.size() - 1 - i];
    return (sum == 0) ? 32'd1 : sum[31:0];
  endfunction

  function automatic longint set_total();
    longint sum;
    sum = 0;
    foreach (set_values[i]) sum += set_values[i];
    return sum;
  endfunction

  initial begin : stimulus
    int        sent;
    int        phase;
    int        len;
    bit [31:0] amt;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: amount still at its reset value of one
    set_values = '{16'd1};                    // whole set removed, target zero
    send_set(1'b0);
    set_values = '{16'd5};                    // target four, no run matches
    send_set(1'b1);
    set_values = '{16'd2, 16'd0, 16'd1, 16'd0}; // zero elements stretch the window
    send_set(1'b0);

    // largest amount: target negative
    wait_idle();
    write_amount(32'hFFFF_FFFF);
    set_values = '{16'hFFFF, 16'h8000};
    send_set(1'b1);

    // longest run is the single maximum element in the middle
    wait_idle();
    write_amount(32'd7);
    set_values = '{16'd3, 16'hFFFF, 16'd4};
    send_set(1'b0);

    // total equals amount exactly
    wait_idle();
    write_amount(32'd10);
    set_values = '{16'd10};
    send_set(1'b1);

    // random phases: each sets amount while idle, then sends one or two data sets;
    // mostly the amount is built from the set so that the window search has work
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BEATS || phase <= SPILL_PHASE) begin
      if (phase == FULL_PHASE)
        len = STORE_DEPTH;
      else if (phase == SPILL_PHASE)
        len = STORE_DEPTH + $urandom_range(1, 8);
      else
        len = $urandom_range(1, 16);
      build_set(len, (len >= STORE_DEPTH) ? 0 : $urandom_range(0, 9));

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: amt = reachable_amount();
        7:                   amt = ($urandom() == 0) ? 32'd1 : $urandom();
        8:                   amt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
        default:             amt = 32'(set_total() + $urandom_range(1, 5));
      endcase

      // the sender holds off here until every earlier result has come back
      wait_idle();
      write_amount(amt);
      send_set($urandom_range(0, 3) == 0);
      if (len < STORE_DEPTH) sent += len;

      // a second set under the same amount, content unrelated to it
      if ($urandom_range(0, 1) == 0) begin
        build_set($urandom_range(1, 12), $urandom_range(0, 9));
        send_set($urandom_range(0, 3) == 0);
        sent += set_values.size();
      end
      phase++;
    end

    // drain, then allow for anything still in flight
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
